// ----- src/rsb_pkg.sv -----
// ----------------------------------------------------------------------------
// rsb_pkg: shared types and constants of the rank/select bit vector
// Sizes of the stores, item codes, memory request structs, count helpers.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int MAX_WORDS    = 1024;
  localparam int WORD_AW      = 10;
  localparam int SUPER_DEPTH  = 129;
  localparam int SUPER_AW     = 8;
  localparam int SAMPLE_DEPTH = 130;
  localparam int SAMPLE_AW    = 8;
  localparam int CNT_W        = 17;
  localparam int FIELD_W      = 9;
  localparam int BLOCKS_W     = 63;
  localparam int LINEAR_FALLBACK = 4;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_ACCESS = 3'd1,
    FN_RANK   = 3'd2,
    FN_SELECT = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_SEL_OFF = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_POP, S_LD_WR, S_Q_RD, S_Q_POP, S_Q_SUM,
    S_SEL_CHK, S_SEL_LO, S_SEL_HI, S_BS, S_BS_CMP, S_LIN, S_LIN_CMP,
    S_SB, S_BLK, S_BLK2, S_WRD, S_SCAN, S_SEL_END, S_DONE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]    super_cnt;
    logic [BLOCKS_W-1:0] blocks;
  } rank_entry_t;

  typedef struct packed {
    logic                we;
    logic [SUPER_AW-1:0] waddr;
    rank_entry_t         wdata;
    logic                re;
    logic [SUPER_AW-1:0] raddr;
  } rank_req_t;

  typedef struct packed {
    logic                 one_we;
    logic [SAMPLE_AW-1:0] one_addr;
    logic                 zero_we;
    logic [SAMPLE_AW-1:0] zero_addr;
    logic [7:0]           wdata;
    logic                 re;
    logic [SAMPLE_AW-1:0] raddr;
  } sample_req_t;

  typedef struct packed {
    logic [7:0] one_smp;
    logic [7:0] zero_smp;
  } sample_rd_t;

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) c = c + 7'(x[i]);
    return c;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = c + 4'(x[i]);
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] field_get(input logic [BLOCKS_W-1:0] b,
                                                   input logic [2:0] j);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int i = 1; i < 8; i++) begin
      if (j == 3'(i)) f = b[FIELD_W*(i-1) +: FIELD_W];
    end
    return f;
  endfunction

endpackage

// ----- src/rsb_word_ram.sv -----
// ----------------------------------------------------------------------------
// rsb_word_ram: bit word store
// One write port, one registered read port, no reset contents.
// ----------------------------------------------------------------------------
module rsb_word_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rsb_pkg::WORD_AW-1:0] waddr_i,
  input  logic [63:0]                 wdata_i,
  input  logic                        re_i,
  input  logic [rsb_pkg::WORD_AW-1:0] raddr_i,
  output logic [63:0]                 rdata_o
);

  logic [63:0] mem [rsb_pkg::MAX_WORDS];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rsb_rank_ram.sv -----
// ----------------------------------------------------------------------------
// rsb_rank_ram: superblock rank table
// Absolute and per-block ranks per superblock; valid bits make clear instant.
// ----------------------------------------------------------------------------
module rsb_rank_ram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  rsb_pkg::rank_req_t   req_i,
  output rsb_pkg::rank_entry_t rdata_o
);

  rsb_pkg::rank_entry_t mem [rsb_pkg::SUPER_DEPTH];
  rsb_pkg::rank_entry_t rdata_q;
  logic [rsb_pkg::SUPER_DEPTH-1:0] valid_q;
  logic rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (clear_i) valid_q <= '0;
      else if (req_i.we) valid_q[req_i.waddr] <= 1'b1;
      if (req_i.re) rvld_q <= valid_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.re) rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- src/rsb_sample_ram.sv -----
// ----------------------------------------------------------------------------
// rsb_sample_ram: select sample tables
// Superblock marks for ones and zeros; valid bits make clear instant.
// ----------------------------------------------------------------------------
module rsb_sample_ram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  rsb_pkg::sample_req_t req_i,
  output rsb_pkg::sample_rd_t  rdata_o
);

  logic [7:0] one_mem  [rsb_pkg::SAMPLE_DEPTH];
  logic [7:0] zero_mem [rsb_pkg::SAMPLE_DEPTH];
  logic [rsb_pkg::SAMPLE_DEPTH-1:0] one_vld_q, zero_vld_q;
  logic [7:0] one_rd_q, zero_rd_q;
  logic one_rv_q, zero_rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_vld_q  <= '0;
      zero_vld_q <= '0;
      one_rv_q   <= 1'b0;
      zero_rv_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        one_vld_q  <= '0;
        zero_vld_q <= '0;
      end else begin
        if (req_i.one_we) one_vld_q[req_i.one_addr] <= 1'b1;
        if (req_i.zero_we) zero_vld_q[req_i.zero_addr] <= 1'b1;
      end
      if (req_i.re) begin
        one_rv_q  <= one_vld_q[req_i.raddr];
        zero_rv_q <= zero_vld_q[req_i.raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.one_we) one_mem[req_i.one_addr] <= req_i.wdata;
    if (req_i.zero_we) zero_mem[req_i.zero_addr] <= req_i.wdata;
    if (req_i.re) begin
      one_rd_q  <= one_mem[req_i.raddr];
      zero_rd_q <= zero_mem[req_i.raddr];
    end
  end

  assign rdata_o.one_smp  = one_rv_q ? one_rd_q : '0;
  assign rdata_o.zero_smp = zero_rv_q ? zero_rd_q : '0;

endmodule

// ----- src/rank_select_bit_vector.sv -----
// ----------------------------------------------------------------------------
// rank_select_bit_vector: succinct bit vector with rank and select
// Loads append words and build rank and select tables; queries answer them.
// ----------------------------------------------------------------------------
// One word is taken at a time and each gives one result word. A load does
// a popcount, then the table and store writes, then fills the result
// register. Access and rank do one read of the rank table and word store, a
// masked popcount, and the final add. Select does two sample reads, a binary
// then linear search over superblocks with one rank-table read per step, a
// block pick, one word read and a scan of the eight bytes of the word. Clear
// takes effect at once through valid bits; there is no clearing pass. The
// output register holds a result until it is taken.
// ----------------------------------------------------------------------------
module rank_select_bit_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic        bit_value_i,
  input  logic [63:0] data_word_i,
  input  logic [6:0]  valid_bits_i,
  input  logic [16:0] query_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        bit_out_o,
  output logic [16:0] count_out_o,
  output logic [1:0]  status_o
);

  rsb_pkg::state_e state_q, state_d;

  logic [16:0] length_q, length_d, ones_q, ones_d, cur_super_q, cur_super_d;
  logic [62:0] cur_blocks_q, cur_blocks_d;
  logic closed_q, closed_d, sel_en_q, sel_en_d, out_valid_q, out_valid_d;

  logic [2:0]  func_q, func_d;
  logic        bv_q, bv_d;
  logic [63:0] data_q, data_d;
  logic [6:0]  vb_q, vb_d, v_q, v_d, pc_q, pc_d, pop_q, pop_d;
  logic [16:0] qi_q, qi_d, base_q, base_d, rem_q, rem_d, rem2_q, rem2_d;
  logic        bit_q, bit_d, wi_ok_q, wi_ok_d, found_q, found_d;
  logic [7:0]  low_q, low_d, high_q, high_d, mid_q, mid_d, s_q, s_d;
  logic [62:0] blocks_q, blocks_d;
  logic [2:0]  j_q, j_d, byte_q, byte_d;
  logic [63:0] scan_q, scan_d;
  logic [5:0]  idx_q, idx_d;
  logic        res_bit_q, res_bit_d, obit_q, obit_d;
  logic [16:0] res_cnt_q, res_cnt_d, ocnt_q, ocnt_d;
  logic [1:0]  res_st_q, res_st_d, ost_q, ost_d;

  logic                  clear;
  logic                  w_we, w_re;
  logic [9:0]            w_waddr, w_raddr;
  logic [63:0]           w_wdata, w_rdata;
  rsb_pkg::rank_req_t    rreq;
  rsb_pkg::rank_entry_t  rrd;
  rsb_pkg::sample_req_t  sreq;
  rsb_pkg::sample_rd_t   srd;

  rsb_word_ram u_words (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  rsb_rank_ram u_rank (
    .clk_i, .rst_ni, .clear_i(clear), .req_i(rreq), .rdata_o(rrd)
  );

  rsb_sample_ram u_smp (
    .clk_i, .rst_ni, .clear_i(clear), .req_i(sreq), .rdata_o(srd)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rsb_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign bit_out_o   = obit_q;
  assign count_out_o = ocnt_q;
  assign status_o    = ost_q;

  always_comb begin
    logic [6:0]  v;
    logic [63:0] mask;
    logic [16:0] new_len, new_ones, zeros_prev, total, cum, r1, bcum;
    logic [9:0]  sum_one, sum_zero;
    logic [8:0]  fval, sum9, nsamp, top, hi9;
    logic [11:0] nw_full;
    logic [3:0]  nw;
    logic [2:0]  jres;
    logic        go, sel, hit;
    logic [10:0] wi;
    logic [63:0] wsel;
    logic [7:0]  b8;
    logic [3:0]  pc8;
    logic [2:0]  pos, cnt3;
    logic [62:0] blocks_new;

    state_d = state_q;
    length_d = length_q; ones_d = ones_q; closed_d = closed_q;
    cur_super_d = cur_super_q; cur_blocks_d = cur_blocks_q;
    sel_en_d = sel_en_q; out_valid_d = out_valid_q;
    func_d = func_q; bv_d = bv_q; data_d = data_q; vb_d = vb_q; qi_d = qi_q;
    v_d = v_q; pc_d = pc_q; pop_d = pop_q; base_d = base_q; bit_d = bit_q;
    low_d = low_q; high_d = high_q; mid_d = mid_q; s_d = s_q;
    rem_d = rem_q; rem2_d = rem2_q; blocks_d = blocks_q; j_d = j_q;
    wi_ok_d = wi_ok_q; scan_d = scan_q; byte_d = byte_q; found_d = found_q;
    idx_d = idx_q; res_bit_d = res_bit_q; res_cnt_d = res_cnt_q;
    res_st_d = res_st_q; obit_d = obit_q; ocnt_d = ocnt_q; ost_d = ost_q;

    clear = 1'b0;
    w_we = 1'b0; w_re = 1'b0; w_waddr = '0; w_raddr = '0; w_wdata = data_q;
    rreq = '0; sreq = '0;

    v = '0; mask = '0; new_len = '0; new_ones = '0; zeros_prev = '0;
    total = '0; cum = '0; r1 = '0; bcum = '0; sum_one = '0; sum_zero = '0;
    fval = '0; sum9 = '0; nsamp = '0; top = '0; hi9 = '0; nw_full = '0;
    nw = '0; jres = '0; go = 1'b0; sel = 1'b0; hit = 1'b0; wi = '0;
    wsel = '0; b8 = '0; pc8 = '0; pos = '0; cnt3 = '0; blocks_new = '0;

    if (cfg_valid_i) sel_en_d = cfg_data_i;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    total = bv_q ? ones_q : (length_q - ones_q);
    cum   = bv_q ? rrd.super_cnt : ({mid_q, 9'b0} - rrd.super_cnt);

    case (state_q)
      rsb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i; bv_d = bit_value_i; data_d = data_word_i;
          vb_d = valid_bits_i; qi_d = query_index_i;
          res_bit_d = 1'b0; res_cnt_d = '0; res_st_d = rsb_pkg::ST_OK;
          case (func_i)
            rsb_pkg::FN_LOAD: state_d = rsb_pkg::S_LD_POP;
            rsb_pkg::FN_ACCESS, rsb_pkg::FN_RANK: state_d = rsb_pkg::S_Q_RD;
            rsb_pkg::FN_SELECT: state_d = rsb_pkg::S_SEL_CHK;
            rsb_pkg::FN_CLEAR: begin
              clear = 1'b1;
              length_d = '0; ones_d = '0; closed_d = 1'b0;
              cur_super_d = '0; cur_blocks_d = '0;
              state_d = rsb_pkg::S_DONE;
            end
            default: begin
              res_st_d = rsb_pkg::ST_RANGE;
              state_d = rsb_pkg::S_DONE;
            end
          endcase
        end
      end
      rsb_pkg::S_LD_POP: begin
        v = (vb_q > 7'd64) ? 7'd64 : vb_q;
        if (closed_q || length_q[16]) begin
          res_st_d = rsb_pkg::ST_FULL;
          state_d = rsb_pkg::S_DONE;
        end else if (v == 7'd0) begin
          closed_d = 1'b1;
          res_cnt_d = length_q;
          state_d = rsb_pkg::S_DONE;
        end else begin
          mask = (v == 7'd64) ? '1 : ((64'd1 << v[5:0]) - 64'd1);
          data_d = data_q & mask;
          pc_d = rsb_pkg::pop64(data_q & mask);
          v_d = v;
          state_d = rsb_pkg::S_LD_WR;
        end
      end
      rsb_pkg::S_LD_WR: begin
        new_len = length_q + 17'(v_q);
        new_ones = ones_q + 17'(pc_q);
        zeros_prev = length_q - ones_q;
        sum_one = {1'b0, ones_q[8:0]} + 10'(pc_q);
        sum_zero = {1'b0, zeros_prev[8:0]} + 10'(v_q - pc_q);
        sreq.wdata = length_q[16:9] + 8'd1;
        sreq.one_we = sum_one[9];
        sreq.one_addr = ones_q[16:9] + 8'd1;
        sreq.zero_we = sum_zero[9];
        sreq.zero_addr = zeros_prev[16:9] + 8'd1;
        w_we = 1'b1;
        w_waddr = length_q[15:6];
        fval = 9'(new_ones - cur_super_q);
        blocks_new = cur_blocks_q;
        for (int jj = 0; jj < 7; jj++) begin
          if (length_q[8:6] == 3'(jj)) blocks_new[9*jj +: 9] = fval;
        end
        if (length_q[8:6] != 3'd7) begin
          rreq.we = 1'b1;
          rreq.waddr = {1'b0, length_q[15:9]};
          rreq.wdata.super_cnt = cur_super_q;
          rreq.wdata.blocks = blocks_new;
          cur_blocks_d = blocks_new;
        end else if (v_q == 7'd64) begin
          rreq.we = 1'b1;
          rreq.waddr = {1'b0, length_q[15:9]} + 8'd1;
          rreq.wdata.super_cnt = new_ones;
          rreq.wdata.blocks = '0;
          cur_super_d = new_ones;
          cur_blocks_d = '0;
        end
        length_d = new_len;
        ones_d = new_ones;
        if (v_q != 7'd64) closed_d = 1'b1;
        res_cnt_d = new_len;
        state_d = rsb_pkg::S_DONE;
      end
      rsb_pkg::S_Q_RD: begin
        if ((func_q == rsb_pkg::FN_ACCESS) ? (qi_q >= length_q) : (qi_q > length_q)) begin
          res_st_d = rsb_pkg::ST_RANGE;
          state_d = rsb_pkg::S_DONE;
        end else begin
          rreq.re = 1'b1;
          rreq.raddr = qi_q[16:9];
          w_re = 1'b1;
          w_raddr = qi_q[15:6];
          state_d = rsb_pkg::S_Q_POP;
        end
      end
      rsb_pkg::S_Q_POP: begin
        mask = (64'd1 << qi_q[5:0]) - 64'd1;
        pop_d = rsb_pkg::pop64(w_rdata & mask);
        base_d = rrd.super_cnt + 17'(rsb_pkg::field_get(rrd.blocks, qi_q[8:6]));
        bit_d = w_rdata[qi_q[5:0]];
        state_d = rsb_pkg::S_Q_SUM;
      end
      rsb_pkg::S_Q_SUM: begin
        r1 = base_q + 17'(pop_q);
        sel = (func_q == rsb_pkg::FN_ACCESS) ? bit_q : bv_q;
        res_cnt_d = sel ? r1 : (qi_q - r1);
        res_bit_d = (func_q == rsb_pkg::FN_ACCESS) ? bit_q : 1'b0;
        state_d = rsb_pkg::S_DONE;
      end
      rsb_pkg::S_SEL_CHK: begin
        if (!sel_en_q) begin
          res_st_d = rsb_pkg::ST_SEL_OFF;
          state_d = rsb_pkg::S_DONE;
        end else if (qi_q >= total) begin
          res_st_d = rsb_pkg::ST_RANGE;
          state_d = rsb_pkg::S_DONE;
        end else begin
          sreq.re = 1'b1;
          sreq.raddr = qi_q[16:9];
          state_d = rsb_pkg::S_SEL_LO;
        end
      end
      rsb_pkg::S_SEL_LO: begin
        low_d = bv_q ? srd.one_smp : srd.zero_smp;
        sreq.re = 1'b1;
        sreq.raddr = qi_q[16:9] + 8'd1;
        state_d = rsb_pkg::S_SEL_HI;
      end
      rsb_pkg::S_SEL_HI: begin
        nsamp = {1'b0, total[16:9]} + 9'd1;
        top = {1'b0, length_q[16:9]} + 9'd1;
        hi9 = ({1'b0, qi_q[16:9]} + 9'd1 < nsamp) ?
              {1'b0, (bv_q ? srd.one_smp : srd.zero_smp)} : top;
        if (hi9 > top) hi9 = top;
        high_d = hi9[7:0];
        state_d = rsb_pkg::S_BS;
      end
      rsb_pkg::S_BS: begin
        if ({1'b0, low_q} + 9'(rsb_pkg::LINEAR_FALLBACK) < {1'b0, high_q}) begin
          sum9 = {1'b0, low_q} + {1'b0, high_q};
          mid_d = sum9[8:1];
          rreq.re = 1'b1;
          rreq.raddr = sum9[8:1];
          state_d = rsb_pkg::S_BS_CMP;
        end else begin
          state_d = rsb_pkg::S_LIN;
        end
      end
      rsb_pkg::S_BS_CMP: begin
        if (qi_q >= cum) low_d = mid_q + 8'd1;
        else high_d = mid_q;
        state_d = rsb_pkg::S_BS;
      end
      rsb_pkg::S_LIN: begin
        if (low_q < high_q) begin
          mid_d = low_q;
          rreq.re = 1'b1;
          rreq.raddr = low_q;
          state_d = rsb_pkg::S_LIN_CMP;
        end else begin
          state_d = rsb_pkg::S_SB;
        end
      end
      rsb_pkg::S_LIN_CMP: begin
        if (cum <= qi_q) begin
          low_d = low_q + 8'd1;
          state_d = rsb_pkg::S_LIN;
        end else begin
          state_d = rsb_pkg::S_SB;
        end
      end
      rsb_pkg::S_SB: begin
        s_d = (low_q != 8'd0) ? low_q - 8'd1 : 8'd0;
        mid_d = s_d;
        rreq.re = 1'b1;
        rreq.raddr = s_d;
        state_d = rsb_pkg::S_BLK;
      end
      rsb_pkg::S_BLK: begin
        rem_d = qi_q - cum;
        blocks_d = rrd.blocks;
        state_d = rsb_pkg::S_BLK2;
      end
      rsb_pkg::S_BLK2: begin
        nw_full = 12'(({1'b0, length_q} + 18'd63) >> 6) - {1'b0, s_q, 3'b0};
        nw = (nw_full > 12'd8) ? 4'd8 : nw_full[3:0];
        jres = '0;
        go = 1'b1;
        for (int jj = 1; jj < 8; jj++) begin
          fval = blocks_q[9*(jj-1) +: 9];
          bcum = bv_q ? 17'(fval) : (17'(jj * 64) - 17'(fval));
          if (go && (4'(jj) < nw) && (rem_q >= bcum)) jres = 3'(jj);
          else go = 1'b0;
        end
        fval = rsb_pkg::field_get(blocks_q, jres);
        bcum = bv_q ? 17'(fval) : ({8'd0, jres, 6'b0} - 17'(fval));
        rem2_d = rem_q - bcum;
        j_d = jres;
        wi = {s_q, 3'b0} + 11'(jres);
        wi_ok_d = !wi[10];
        w_re = 1'b1;
        w_raddr = wi[9:0];
        state_d = rsb_pkg::S_WRD;
      end
      rsb_pkg::S_WRD: begin
        wsel = wi_ok_q ? w_rdata : '0;
        scan_d = bv_q ? wsel : ~wsel;
        byte_d = '0;
        found_d = 1'b0;
        idx_d = 6'd63;
        state_d = rsb_pkg::S_SCAN;
      end
      rsb_pkg::S_SCAN: begin
        wsel = scan_q >> {byte_q, 3'b0};
        b8 = wsel[7:0];
        pc8 = rsb_pkg::pop8(b8);
        if (!found_q) begin
          if (rem2_q < 17'(pc8)) begin
            cnt3 = '0;
            hit = 1'b0;
            for (int i = 0; i < 8; i++) begin
              if (b8[i] && !hit) begin
                if (cnt3 == rem2_q[2:0]) begin
                  pos = 3'(i);
                  hit = 1'b1;
                end
                cnt3 = cnt3 + 3'd1;
              end
            end
            idx_d = {byte_q, pos};
            found_d = 1'b1;
          end else begin
            rem2_d = rem2_q - 17'(pc8);
          end
        end
        byte_d = byte_q + 3'd1;
        if (byte_q == 3'd7) state_d = rsb_pkg::S_SEL_END;
      end
      rsb_pkg::S_SEL_END: begin
        res_cnt_d = {s_q, 9'b0} + {8'd0, j_q, 6'b0} + 17'(idx_q);
        state_d = rsb_pkg::S_DONE;
      end
      rsb_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          obit_d = (res_st_q == rsb_pkg::ST_OK) ? res_bit_q : 1'b0;
          ocnt_d = (res_st_q == rsb_pkg::ST_OK) ? res_cnt_q : '0;
          ost_d = res_st_q;
          state_d = rsb_pkg::S_IDLE;
        end
      end
      default: state_d = rsb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsb_pkg::S_IDLE;
      length_q <= '0;
      ones_q <= '0;
      closed_q <= 1'b0;
      cur_super_q <= '0;
      cur_blocks_q <= '0;
      sel_en_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      length_q <= length_d;
      ones_q <= ones_d;
      closed_q <= closed_d;
      cur_super_q <= cur_super_d;
      cur_blocks_q <= cur_blocks_d;
      sel_en_q <= sel_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; bv_q <= bv_d; data_q <= data_d; vb_q <= vb_d; qi_q <= qi_d;
    v_q <= v_d; pc_q <= pc_d; pop_q <= pop_d; base_q <= base_d; bit_q <= bit_d;
    low_q <= low_d; high_q <= high_d; mid_q <= mid_d; s_q <= s_d;
    rem_q <= rem_d; rem2_q <= rem2_d; blocks_q <= blocks_d; j_q <= j_d;
    wi_ok_q <= wi_ok_d; scan_q <= scan_d; byte_q <= byte_d; found_q <= found_d;
    idx_q <= idx_d; res_bit_q <= res_bit_d; res_cnt_q <= res_cnt_d;
    res_st_q <= res_st_d; obit_q <= obit_d; ocnt_q <= ocnt_d; ost_q <= ost_d;
  end

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= 17'd65536)
    else $error("stored length beyond capacity");

  a_ones_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q <= length_q)
    else $error("ones count exceeds length");

  a_closed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsb_pkg::S_LD_POP && closed_q) |=> $stable(length_q))
    else $error("load changed length after loading closed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(ocnt_q)))
    else $error("result dropped while stalled");

endmodule
